/* hw/rtl/skt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared widths, request codes and a key helper for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int FUNC_W  = 3;
	localparam int KEY_W   = 64;
	localparam int PAY_W   = 32;
	localparam int POS_W   = 7;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_KEY_BYTES   = 8;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INS_POS  = 3'd0,
		FUNC_INS_SORT = 3'd1,
		FUNC_BSEARCH  = 3'd2,
		FUNC_LSEARCH  = 3'd3,
		FUNC_RM_POS   = 3'd4,
		FUNC_RM_KEY   = 3'd5,
		FUNC_CLEAR    = 3'd6
	} func_t;

	// Keep the first nbytes bytes, zero everything from the first zero byte on.
	function automatic logic [KEY_W-1:0] canon_key(logic [KEY_W-1:0] k, int unsigned nbytes);
		logic [KEY_W-1:0] r;
		logic             live;
		r    = '0;
		live = 1'b1;
		for (int i = 0; i < KEY_W / 8; i++) begin
			if (k[KEY_W-1-8*i -: 8] == 8'd0 || i >= nbytes) begin
				live = 1'b0;
			end
			if (live) begin
				r[KEY_W-1-8*i -: 8] = k[KEY_W-1-8*i -: 8];
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/sorted_key_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of key/payload entries at positions 1..count, held in one
// synchronous memory, with positional and sorted insert, binary and linear
// search, positional and keyed removal, and clear.
// ----------------------------------------------------------------------------
//
//   channel | beat fields                                  | handshake
//   --------+----------------------------------------------+---------------------
//   request | func, item_key, item_payload, position       | in_valid / in_ready
//   result  | ok, where, found_payload, count, is_empty,   | out_valid / out_ready
//           | is_full                                      |
//
// One request is in work at a time; in_ready is high only while idle.
// A binary search takes up to log2(TABLE_DEPTH)+1 steps, each a read in
// ST_BS_RD and a compare in ST_BS_CMP. The single memory port pair, one
// entry moved per cycle, sets the pace of a shift.
// Reset clears the entry count and the control state only; the memory is
// not cleared, since only positions 1..count are ever read.
// A held result stalls only the final hand-off: the result register frees
// the engine as soon as out_ready takes the beat.

module sorted_key_table #(
	parameter int TABLE_DEPTH = skt_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_BYTES   = skt_pkg::DEF_KEY_BYTES
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [skt_pkg::FUNC_W-1:0] func,
	input  logic [skt_pkg::KEY_W-1:0]  item_key,
	input  logic [skt_pkg::PAY_W-1:0]  item_payload,
	input  logic [skt_pkg::POS_W-1:0]  position,

	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       ok,
	output logic [skt_pkg::POS_W-1:0]  where,
	output logic [skt_pkg::PAY_W-1:0]  found_payload,
	output logic [skt_pkg::POS_W-1:0]  count,
	output logic                       is_empty,
	output logic                       is_full
);

	// Stored key width follows KEY_BYTES; only those bytes ever differ.
	localparam int KW     = KEY_BYTES * 8;
	localparam int ENT_W  = KW + skt_pkg::PAY_W;
	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int PW_MIN = $clog2(TABLE_DEPTH + 2);
	// Wide enough for position 0..depth+1 and for the full request field.
	localparam int PW     = (PW_MIN > skt_pkg::POS_W) ? PW_MIN : skt_pkg::POS_W;
	localparam logic [PW-1:0] DEPTH_P = PW'(TABLE_DEPTH);
	localparam logic [PW-1:0] ONE_P   = PW'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BS_RD,
		ST_BS_CMP,
		ST_BS_END,
		ST_SHIFT,
		ST_SCAN,
		ST_PUT,
		ST_RM_END,
		ST_RESP
	} state_t;

	state_t                   state_q;
	skt_pkg::func_t           func_q;
	logic [KW-1:0]            key_q;
	logic [skt_pkg::PAY_W-1:0] pay_q;
	logic [PW-1:0]            pos_q;
	logic [PW-1:0]            cnt_q;
	logic [PW-1:0]            lo_q;
	logic [PW-1:0]            hi_q;
	logic [PW-1:0]            mid_q;
	logic                     match_q;

	// Shift / scan sequencer: cur_q walks from its start to stop_q.
	logic [PW-1:0]            cur_q;
	logic [PW-1:0]            stop_q;
	logic                     up_q;
	logic                     iss_q;
	logic                     rv_s1;
	logic [PW-1:0]            ridx_s1;

	// Staged result
	logic                     res_ok_q;
	logic [PW-1:0]            res_where_q;
	logic [skt_pkg::PAY_W-1:0] res_found_q;

	// Result register
	logic                     out_valid_q;
	logic                     out_ok_q;
	logic [skt_pkg::POS_W-1:0] out_where_q;
	logic [skt_pkg::PAY_W-1:0] out_found_q;
	logic [skt_pkg::POS_W-1:0] out_count_q;
	logic                     out_empty_q;
	logic                     out_full_q;

	// Entry memory: key in the top bits, payload below
	logic [ENT_W-1:0]         mem [TABLE_DEPTH];
	logic [ENT_W-1:0]         rd_data_q;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic                     we;
	logic [AW-1:0]            wr_addr;
	logic [ENT_W-1:0]         wr_data;

	logic [KW-1:0]            rd_key;
	logic [skt_pkg::PAY_W-1:0] rd_pay;
	logic [skt_pkg::KEY_W-1:0] canon_w;
	logic [KW-1:0]            key_in;
	logic [PW-1:0]            pos_in;
	skt_pkg::func_t           func_in;
	logic [PW:0]              mid_sum;
	logic [PW-1:0]            mid_w;
	logic [PW-1:0]            mid_m1;
	logic [PW-1:0]            wr_up;
	logic [PW-1:0]            wr_dn;
	logic [PW-1:0]            put_idx;

	assign canon_w = skt_pkg::canon_key(item_key, KEY_BYTES);
	assign key_in  = canon_w[skt_pkg::KEY_W-1 -: KW];
	assign pos_in  = PW'(position);
	assign func_in = skt_pkg::func_t'(func);

	assign rd_key  = rd_data_q[ENT_W-1 -: KW];
	assign rd_pay  = rd_data_q[skt_pkg::PAY_W-1:0];

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w   = mid_sum[PW:1];
	assign mid_m1  = mid_w - ONE_P;
	assign wr_up   = ridx_s1 + ONE_P;
	assign wr_dn   = ridx_s1 - ONE_P;
	assign put_idx = pos_q - ONE_P;

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q[AW-1:0];
		we      = 1'b0;
		wr_addr = put_idx[AW-1:0];
		wr_data = {key_q, pay_q};
		unique case (state_q)
			ST_BS_RD: begin
				rd_en   = (hi_q >= lo_q);
				rd_addr = mid_m1[AW-1:0];
			end
			ST_SHIFT: begin
				// read one ahead, write the beat read last cycle one place over
				rd_en   = iss_q;
				we      = rv_s1;
				wr_addr = up_q ? wr_up[AW-1:0] : wr_dn[AW-1:0];
				wr_data = rd_data_q;
			end
			ST_SCAN: begin
				rd_en = iss_q;
			end
			ST_PUT: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			iss_q       <= 1'b0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rv_s1   <= rd_en && (state_q == ST_SHIFT || state_q == ST_SCAN);
			ridx_s1 <= cur_q;
			// drop the taken beat; a reload in ST_RESP covers that state itself
			if (out_valid_q && out_ready && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q      <= func_in;
						key_q       <= key_in;
						pay_q       <= item_payload;
						pos_q       <= pos_in;
						res_ok_q    <= 1'b0;
						res_where_q <= '0;
						res_found_q <= '0;
						match_q     <= 1'b0;
						lo_q        <= ONE_P;
						hi_q        <= cnt_q;
						state_q     <= ST_RESP;
						case (func_in)
							skt_pkg::FUNC_INS_POS: begin
								if (cnt_q != DEPTH_P && pos_in != '0 &&
									pos_in <= cnt_q + ONE_P) begin
									if (pos_in <= cnt_q) begin
										cur_q   <= cnt_q - ONE_P;
										stop_q  <= pos_in - ONE_P;
										up_q    <= 1'b1;
										iss_q   <= 1'b1;
										state_q <= ST_SHIFT;
									end else begin
										state_q <= ST_PUT;
									end
								end
							end
							skt_pkg::FUNC_INS_SORT,
							skt_pkg::FUNC_BSEARCH,
							skt_pkg::FUNC_RM_KEY: begin
								state_q <= ST_BS_RD;
							end
							skt_pkg::FUNC_LSEARCH: begin
								if (cnt_q != '0) begin
									cur_q   <= '0;
									stop_q  <= cnt_q - ONE_P;
									iss_q   <= 1'b1;
									state_q <= ST_SCAN;
								end
							end
							skt_pkg::FUNC_RM_POS: begin
								if (pos_in != '0 && pos_in <= cnt_q) begin
									if (pos_in < cnt_q) begin
										cur_q   <= pos_in;
										stop_q  <= cnt_q - ONE_P;
										up_q    <= 1'b0;
										iss_q   <= 1'b1;
										state_q <= ST_SHIFT;
									end else begin
										state_q <= ST_RM_END;
									end
								end
							end
							skt_pkg::FUNC_CLEAR: begin
								cnt_q    <= '0;
								res_ok_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_BS_RD: begin
					if (hi_q >= lo_q) begin
						mid_q   <= mid_w;
						state_q <= ST_BS_CMP;
					end else begin
						pos_q   <= lo_q;
						state_q <= ST_BS_END;
					end
				end
				ST_BS_CMP: begin
					priority if (rd_key == key_q) begin
						pos_q       <= mid_q;
						match_q     <= 1'b1;
						res_found_q <= rd_pay;
						state_q     <= ST_BS_END;
					end else if (rd_key < key_q) begin
						lo_q    <= mid_q + ONE_P;
						state_q <= ST_BS_RD;
					end else begin
						hi_q    <= mid_q - ONE_P;
						state_q <= ST_BS_RD;
					end
				end
				ST_BS_END: begin
					state_q <= ST_RESP;
					case (func_q)
						skt_pkg::FUNC_INS_SORT: begin
							// equal key hit: the new entry goes in front of it
							res_found_q <= '0;
							if (cnt_q != DEPTH_P) begin
								if (pos_q <= cnt_q) begin
									cur_q   <= cnt_q - ONE_P;
									stop_q  <= pos_q - ONE_P;
									up_q    <= 1'b1;
									iss_q   <= 1'b1;
									state_q <= ST_SHIFT;
								end else begin
									state_q <= ST_PUT;
								end
							end
						end
						skt_pkg::FUNC_BSEARCH: begin
							res_ok_q    <= match_q;
							res_where_q <= pos_q;
						end
						default: begin
							// keyed removal: the stop point is reported either way
							res_found_q <= '0;
							res_where_q <= pos_q;
							if (match_q) begin
								if (pos_q < cnt_q) begin
									cur_q   <= pos_q;
									stop_q  <= cnt_q - ONE_P;
									up_q    <= 1'b0;
									iss_q   <= 1'b1;
									state_q <= ST_SHIFT;
								end else begin
									state_q <= ST_RM_END;
								end
							end
						end
					endcase
				end
				ST_SHIFT: begin
					if (iss_q) begin
						if (cur_q == stop_q) begin
							iss_q <= 1'b0;
						end else begin
							cur_q <= up_q ? cur_q - ONE_P : cur_q + ONE_P;
						end
					end else if (!rv_s1) begin
						state_q <= up_q ? ST_PUT : ST_RM_END;
					end
				end
				ST_SCAN: begin
					priority if (rv_s1 && rd_key == key_q) begin
						res_ok_q    <= 1'b1;
						res_where_q <= ridx_s1 + ONE_P;
						res_found_q <= rd_pay;
						iss_q       <= 1'b0;
						state_q     <= ST_RESP;
					end else if (iss_q) begin
						if (cur_q == stop_q) begin
							iss_q <= 1'b0;
						end else begin
							cur_q <= cur_q + ONE_P;
						end
					end else if (!rv_s1) begin
						state_q <= ST_RESP;
					end
				end
				ST_PUT: begin
					cnt_q       <= cnt_q + ONE_P;
					res_ok_q    <= 1'b1;
					res_where_q <= pos_q;
					state_q     <= ST_RESP;
				end
				ST_RM_END: begin
					cnt_q       <= cnt_q - ONE_P;
					res_ok_q    <= 1'b1;
					res_where_q <= pos_q;
					state_q     <= ST_RESP;
				end
				ST_RESP: begin
					// hand the beat over once the result register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_ok_q    <= res_ok_q;
						out_where_q <= skt_pkg::POS_W'(res_where_q);
						out_found_q <= res_found_q;
						out_count_q <= skt_pkg::POS_W'(cnt_q);
						out_empty_q <= (cnt_q == '0);
						out_full_q  <= (cnt_q == DEPTH_P);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign ok            = out_ok_q;
	assign where         = out_where_q;
	assign found_payload = out_found_q;
	assign count         = out_count_q;
	assign is_empty      = out_empty_q;
	assign is_full       = out_full_q;

	// Entry count never runs past the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_P)
		else $error("entry count beyond table depth");

	// A shift must never read the entry it writes in the same cycle.
	a_port_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && we) |-> (rd_addr != wr_addr))
		else $error("memory read and write hit the same entry");

	// One request at a time: a taken beat closes the request side.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while another is in work");

	// A result is only loaded when the output side can take it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("pending result dropped");

endmodule
